// ===== sv/kruskal_union_find_mst_macros.svh =====
// Assertion macros for the union-find spanning tree block.
`ifndef KRUSKAL_UNION_FIND_MST_MACROS_SVH
`define KRUSKAL_UNION_FIND_MST_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KUMST_AST_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("kumst: assertion failed");
`define KUMST_AST_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("kumst: assertion failed");
`else
`define KUMST_AST_IMP(lbl, pre, post)
`define KUMST_AST_NXT(lbl, pre, post)
`endif
`endif

// ===== sv/kumst_pkg.sv =====
// Types and constants shared by the union-find spanning tree block.
package kumst_pkg;

	localparam int MAX_VERTICES = 256;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int WEIGHT_BITS  = 16;
	localparam int WEIGHT_IN_W  = 16;
	localparam int VC_W         = 9;
	localparam int RANK_W       = 4;
	localparam int SUM_W        = 32;
	localparam int CNT_W        = 8;

	localparam logic [VC_W-1:0]   VC_RESET = VC_W'(256);
	localparam logic [RANK_W-1:0] RANK_MAX = '1;
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
	localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [IDX_W-1:0]  parent;
	} node_t;

	typedef struct packed {
		logic             clear;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		node_t            wr_data;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK_S,
		ST_WALK_D,
		ST_JOIN,
		ST_RANK,
		ST_FIN
	} state_t;

endpackage

// ===== sv/kumst_edge_if.sv =====
// Request channel carrying one sorted edge.
interface kumst_edge_if;
	logic                              valid;
	logic                              ready;
	logic                              new_graph;
	logic [kumst_pkg::IDX_W-1:0]       src_index;
	logic [kumst_pkg::IDX_W-1:0]       dest_index;
	logic [kumst_pkg::WEIGHT_IN_W-1:0] edge_weight;

	modport source (output valid, new_graph, src_index, dest_index, edge_weight, input ready);
	modport sink (input valid, new_graph, src_index, dest_index, edge_weight, output ready);
endinterface

// ===== sv/kumst_result_if.sv =====
// Result channel carrying the decision and running totals.
interface kumst_result_if;
	logic                        valid;
	logic                        ready;
	logic                        edge_taken;
	logic                        bad_index;
	logic [kumst_pkg::SUM_W-1:0] total_weight;
	logic [kumst_pkg::CNT_W-1:0] tree_edges;

	modport source (output valid, edge_taken, bad_index, total_weight, tree_edges, input ready);
	modport sink (input valid, edge_taken, bad_index, total_weight, tree_edges, output ready);
endinterface

// ===== sv/kumst_forest.sv =====
// Forest memory: parent link and rank per vertex, with valid bits for fast clear.
module kumst_forest (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kumst_pkg::mem_req_t         req,
	output kumst_pkg::node_t            rsp
);

	kumst_pkg::node_t                        mem_q [kumst_pkg::MAX_VERTICES];
	logic [kumst_pkg::MAX_VERTICES-1:0]      vld_q;
	kumst_pkg::node_t                        rd_data_s1;
	logic [kumst_pkg::IDX_W-1:0]             rd_addr_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		rd_data_s1 <= mem_q[req.rd_addr];
		rd_addr_s1 <= req.rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.clear) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[req.wr_addr] <= 1'b1;
		end
	end

	// unwritten entry: own parent, rank zero
	always_comb begin
		if (vld_q[rd_addr_s1]) begin
			rsp = rd_data_s1;
		end else begin
			rsp.rank   = '0;
			rsp.parent = rd_addr_s1;
		end
	end

endmodule

// ===== sv/kumst_ctrl.sv =====
// Sequencer: root walks, union by rank, totals and result register.
`include "kruskal_union_find_mst_macros.svh"
module kumst_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [kumst_pkg::VC_W-1:0]      cfg_data,
	kumst_edge_if.sink                      edge_in,
	kumst_result_if.source                  result_out,
	output kumst_pkg::mem_req_t             req,
	input  kumst_pkg::node_t                rsp
);

	kumst_pkg::state_t                   state_q, state_d;
	logic [kumst_pkg::VC_W-1:0]          vc_q;
	logic [kumst_pkg::IDX_W-1:0]         cur_q, d_q, root_s_q, root_d_q;
	logic [kumst_pkg::RANK_W-1:0]        rank_s_q, rank_d_q;
	logic [kumst_pkg::WEIGHT_BITS-1:0]   w_q;
	logic                                taken_q, bad_q;
	logic [kumst_pkg::SUM_W-1:0]         sum_q, out_sum_q;
	logic [kumst_pkg::CNT_W-1:0]         count_q, out_count_q;
	logic                                out_valid_q, out_taken_q, out_bad_q;
	logic                                accept, bad_in, out_free, at_root;
	logic [kumst_pkg::SUM_W:0]           sum_ext;

	assign accept   = (state_q == kumst_pkg::ST_IDLE) && edge_in.valid;
	assign bad_in   = ({1'b0, edge_in.src_index} >= vc_q) || ({1'b0, edge_in.dest_index} >= vc_q);
	assign out_free = !out_valid_q || result_out.ready;
	assign at_root  = (rsp.parent == cur_q);
	assign sum_ext  = {1'b0, sum_q} + (kumst_pkg::SUM_W + 1)'(w_q);

	assign edge_in.ready           = (state_q == kumst_pkg::ST_IDLE);
	assign result_out.valid        = out_valid_q;
	assign result_out.edge_taken   = out_taken_q;
	assign result_out.bad_index    = out_bad_q;
	assign result_out.total_weight = out_sum_q;
	assign result_out.tree_edges   = out_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kumst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		req.clear       = 1'b0;
		req.rd_addr     = cur_q;
		req.wr_en       = 1'b0;
		req.wr_addr     = root_d_q;
		req.wr_data     = '{rank: rank_d_q, parent: root_s_q};
		unique case (state_q)
			kumst_pkg::ST_IDLE: begin
				req.rd_addr = edge_in.src_index;
				if (edge_in.valid) begin
					req.clear = edge_in.new_graph;
					state_d   = bad_in ? kumst_pkg::ST_FIN : kumst_pkg::ST_WALK_S;
				end
			end
			kumst_pkg::ST_WALK_S: begin
				if (at_root) begin
					req.rd_addr = d_q;
					state_d     = kumst_pkg::ST_WALK_D;
				end else begin
					req.rd_addr = rsp.parent;
				end
			end
			kumst_pkg::ST_WALK_D: begin
				if (at_root) begin
					state_d = (cur_q == root_s_q) ? kumst_pkg::ST_FIN : kumst_pkg::ST_JOIN;
				end else begin
					req.rd_addr = rsp.parent;
				end
			end
			kumst_pkg::ST_JOIN: begin
				req.wr_en = 1'b1;
				state_d   = kumst_pkg::ST_FIN;
				if (rank_s_q < rank_d_q) begin
					req.wr_addr = root_s_q;
					req.wr_data = '{rank: rank_s_q, parent: root_d_q};
				end else if (rank_s_q == rank_d_q && rank_s_q != kumst_pkg::RANK_MAX) begin
					state_d = kumst_pkg::ST_RANK;
				end
			end
			kumst_pkg::ST_RANK: begin
				req.wr_en   = 1'b1;
				req.wr_addr = root_s_q;
				req.wr_data = '{rank: rank_s_q + 1'b1, parent: root_s_q};
				state_d     = kumst_pkg::ST_FIN;
			end
			kumst_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = kumst_pkg::ST_IDLE;
				end
			end
			default: state_d = kumst_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q        <= kumst_pkg::VC_RESET;
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				vc_q <= cfg_data;
			end
			if (accept && edge_in.new_graph) begin
				sum_q   <= '0;
				count_q <= '0;
			end else if (state_q == kumst_pkg::ST_JOIN) begin
				sum_q <= sum_ext[kumst_pkg::SUM_W] ? kumst_pkg::SUM_MAX
					: sum_ext[kumst_pkg::SUM_W-1:0];
				if (count_q != kumst_pkg::CNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (state_q == kumst_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			kumst_pkg::ST_IDLE: begin
				cur_q   <= edge_in.src_index;
				d_q     <= edge_in.dest_index;
				w_q     <= edge_in.edge_weight[kumst_pkg::WEIGHT_BITS-1:0];
				bad_q   <= bad_in;
				taken_q <= 1'b0;
			end
			kumst_pkg::ST_WALK_S: begin
				if (at_root) begin
					root_s_q <= cur_q;
					rank_s_q <= rsp.rank;
					cur_q    <= d_q;
				end else begin
					cur_q <= rsp.parent;
				end
			end
			kumst_pkg::ST_WALK_D: begin
				if (at_root) begin
					root_d_q <= cur_q;
					rank_d_q <= rsp.rank;
				end else begin
					cur_q <= rsp.parent;
				end
			end
			kumst_pkg::ST_JOIN: begin
				taken_q <= 1'b1;
			end
			kumst_pkg::ST_RANK: begin
			end
			kumst_pkg::ST_FIN: begin
				if (out_free) begin
					out_taken_q <= taken_q;
					out_bad_q   <= bad_q;
					out_sum_q   <= sum_q;
					out_count_q <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

	`KUMST_AST_IMP(a_join_roots_differ, state_q == kumst_pkg::ST_JOIN, root_s_q != root_d_q)
	`KUMST_AST_IMP(a_flags_exclusive, out_valid_q, !(out_taken_q && out_bad_q))
	`KUMST_AST_NXT(a_count_monotonic, !(accept && edge_in.new_graph), count_q >= $past(count_q))
	`KUMST_AST_IMP(a_clear_no_write, req.clear, !req.wr_en)

endmodule

// ===== sv/kruskal_union_find_mst.sv =====
// Top level of the union-find minimum spanning tree builder.
//  channel      dir  handshake       payload
//  edge_in      in   valid/ready     new_graph, src_index, dest_index, edge_weight
//  result_out   out  valid/ready     edge_taken, bad_index, total_weight, tree_edges
//  cfg          in   cfg_we          cfg_data = vertex_count
// A rejected edge goes from idle straight to the finish state. Otherwise the walks from src and dest to their roots
// follow the registered read port of the forest memory, then a join when the roots differ and a rank step on a tie.
// The rank step runs only when ranks tie below the top rank. Hops per walk stay within log2 of the vertex count under
// union by rank. Reset and new_graph clear the forest at once through per-entry valid bits.
// A request is taken while a result waits; the next result waits for out ready.
module kruskal_union_find_mst (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [kumst_pkg::VC_W-1:0] cfg_data,
	kumst_edge_if.sink                 edge_in,
	kumst_result_if.source             result_out
);

	kumst_pkg::mem_req_t mem_req;
	kumst_pkg::node_t    mem_rsp;

	kumst_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.edge_in    (edge_in),
		.result_out (result_out),
		.req        (mem_req),
		.rsp        (mem_rsp)
	);

	kumst_forest u_forest (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rsp    (mem_rsp)
	);

endmodule
